// File: hdl/cartesian_spherical_converter_defines.svh
// ---------------------------------------------------------------------------
// Cartesian/spherical converter assertion macros
// Shared assertion forms used by the converter RTL.
// ---------------------------------------------------------------------------
`ifndef CARTESIAN_SPHERICAL_CONVERTER_DEFINES_SVH
`define CARTESIAN_SPHERICAL_CONVERTER_DEFINES_SVH

// The condition implies the expression in the same cycle.
`define CSC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("csc: assertion failed");

// The condition implies the expression in the following cycle.
`define CSC_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("csc: assertion failed");

`endif

// File: hdl/csc_pkg.sv
// ---------------------------------------------------------------------------
// Converter package
// Shared constants, types and the elaboration-time CORDIC angle table.
// ---------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

  localparam int CSC_COORD_BITS    = 32;
  localparam int CSC_ANGLE_FRAC    = 22;
  localparam int CSC_CORDIC_STAGES = 24;

  localparam int HALF_TURN = 180;

  // Inverse CORDIC gain in Q0.31.
  localparam logic [30:0] GAIN_Q31 = 31'd1304065748;

  localparam longint unsigned SERIES_ONE = 64'd1 << 56;

  typedef enum logic [1:0] {
    OP_TO_SPHERICAL = 2'd0,
    OP_TO_RECT      = 2'd1,
    OP_ROT_X        = 2'd2,
    OP_ROT_Y        = 2'd3
  } csc_op_t;

  // Control that travels with every item along a CORDIC chain.
  typedef struct packed {
    logic valid;
    logic vec;
  } csc_ctl_t;

  // Restoring division, used only while elaborating the angle table.
  function automatic longint unsigned udiv(input longint unsigned n,
                                           input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      if (r >= d) begin
        r = r - d;
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(1/n) in radians with 56 fraction bits, by the alternating series.
  function automatic longint unsigned atan_recip(input longint unsigned n);
    longint unsigned t;
    longint unsigned s;
    longint unsigned k;
    longint unsigned term;
    t = udiv(SERIES_ONE, n);
    s = 0;
    k = 0;
    while (t != 0) begin
      term = udiv(t, 2 * k + 1);
      if (k[0]) s = s - term;
      else s = s + term;
      t = udiv(udiv(t, n), n);
      k = k + 1;
    end
    return s;
  endfunction

  // atan(2^-stage) in degrees with angle_frac fraction bits, rounded.
  function automatic longint atan_deg(input int stage, input int angle_frac);
    longint unsigned quarter;
    longint unsigned num;
    longint unsigned q;
    longint unsigned r;
    if (stage == 0) return longint'(HALF_TURN / 4) <<< angle_frac;
    quarter = 4 * atan_recip(64'd5) - atan_recip(64'd239);
    num = 45 * atan_recip(64'd1 << stage);
    q = udiv(num, quarter);
    r = num - q * quarter;
    for (int b = 0; b <= angle_frac; b++) begin
      r = r << 1;
      q = q << 1;
      if (r >= quarter) begin
        r = r - quarter;
        q = q | 64'd1;
      end
    end
    return longint'((q + 1) >> 1);
  endfunction

endpackage

`default_nettype wire

// File: hdl/cartesian_spherical_converter.sv
// ---------------------------------------------------------------------------
// Cartesian/spherical converter
// Rectangular/spherical conversion and axis rotation of 3-D vectors.
// ---------------------------------------------------------------------------
// Usage: an item enters on item_valid/item_ready with an operation code, three
// coordinates and a rotation angle. Operation 0 converts rectangular to
// spherical, 1 spherical to rectangular, 2 and 3 rotate about the x or y axis
// and then convert to spherical. Every item yields exactly one result on
// result_valid/result_ready with x, y, z, radius, longitude and latitude.
// From acceptance to result_valid an item passes the input register, the angle
// wrap and fold stages, three CORDIC chains in series, each of CORDIC_STAGES
// cells plus two gain-removal stages, the glue stages and the output register.
// Throughput is one item per cycle while results are taken: items flow back to
// back through the chains. When the receiver stalls a waiting result, the whole
// pipeline holds and item_ready drops in the same cycle; nothing is lost or
// repeated. Reset clears every valid flag, so the block comes out of reset
// empty and ready. While reset is high, item_ready is held low so no item is
// taken. There is no configuration and no memory to clear.
// ---------------------------------------------------------------------------
`default_nettype none
`include "cartesian_spherical_converter_defines.svh"

module cartesian_spherical_converter
  import csc_pkg::*;
#(
  parameter int COORD_BITS    = CSC_COORD_BITS,
  parameter int ANGLE_FRAC    = CSC_ANGLE_FRAC,
  parameter int CORDIC_STAGES = CSC_CORDIC_STAGES
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_ready,
  input  logic [1:0]                   operation,
  input  logic signed [COORD_BITS-1:0] first_coord,
  input  logic signed [COORD_BITS-1:0] second_coord,
  input  logic signed [COORD_BITS-1:0] third_coord,
  input  logic signed [ANGLE_FRAC+9:0] rotation_angle,
  output logic                         result_valid,
  input  logic                         result_ready,
  output logic signed [COORD_BITS-1:0] x_out,
  output logic signed [COORD_BITS-1:0] y_out,
  output logic signed [COORD_BITS-1:0] z_out,
  output logic        [COORD_BITS-2:0] radius_out,
  output logic        [ANGLE_FRAC+8:0] longitude_out,
  output logic signed [ANGLE_FRAC+8:0] latitude_out
);

  // Coordinate and angle widths. Angles carry one spare bit so that negated
  // inputs and accumulated CORDIC angles plus a half turn still fit.
  localparam int CB = COORD_BITS;
  localparam int AB = ANGLE_FRAC + 10;
  localparam int AW = ANGLE_FRAC + 11;
  localparam int MW = (CB > AB) ? CB : AB;
  // Working width of the CORDIC datapath: room for the CORDIC growth of a
  // saturated vector, and at least wide enough for the gain split at bit 31.
  localparam int W  = (CB + 4 > 33) ? CB + 4 : 33;

  localparam logic signed [AW-1:0] D90  = AW'(longint'(HALF_TURN / 2) <<< ANGLE_FRAC);
  localparam logic signed [AW-1:0] D180 = AW'(longint'(HALF_TURN) <<< ANGLE_FRAC);
  localparam logic signed [AW-1:0] D270 = AW'(longint'(3 * HALF_TURN / 2) <<< ANGLE_FRAC);
  localparam logic signed [AW-1:0] D360 = AW'(longint'(2 * HALF_TURN) <<< ANGLE_FRAC);
  localparam logic signed [AW-1:0] D720 = AW'(longint'(4 * HALF_TURN) <<< ANGLE_FRAC);

  localparam logic signed [W-1:0] CMAX = W'((longint'(1) <<< (CB - 1)) - 1);
  localparam logic signed [W-1:0] CMIN = -CMAX - W'(1);

  // Side data widths of the three chains.
  localparam int SA_W = 2 + 3 * CB + 3 * AW + 1;
  localparam int SB_W = 2 + CB + 3 + 3 * W + 2 * AW;
  localparam int SC_W = 3 * CB + 2 * AW + 1 + W;

  // Angle wrapped into [0,360).
  function automatic logic signed [AW-1:0] wrap_full(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    if (v < 0) r = (v + D360 < 0) ? v + D720 : v + D360;
    else if (v >= D360) r = v - D360;
    else r = v;
    return r;
  endfunction

  // Angle wrapped into (-180,180].
  function automatic logic signed [AW-1:0] wrap_half(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    if (v > D180) r = (v - D360 > D180) ? v - D720 : v - D360;
    else if (v <= -D180) r = (v + D360 <= -D180) ? v + D720 : v + D360;
    else r = v;
    return r;
  endfunction

  function automatic logic signed [CB-1:0] sat_coord(input logic signed [W-1:0] v);
    logic signed [CB-1:0] r;
    if (v > CMAX) r = CMAX[CB-1:0];
    else if (v < CMIN) r = CMIN[CB-1:0];
    else r = v[CB-1:0];
    return r;
  endfunction

  // A coordinate port read as an angle: its low AB bits, sign extended.
  function automatic logic signed [AW-1:0] ang_of(input logic signed [CB-1:0] c);
    logic signed [MW-1:0] e;
    e = MW'(c);
    return AW'($signed(e[AB-1:0]));
  endfunction

  logic en;

  // Input register.
  logic                 s0_valid;
  logic [1:0]           s0_op;
  logic signed [CB-1:0] s0_c1, s0_c2, s0_c3;
  logic signed [AB-1:0] s0_ang;

  // Angle wrap stage.
  logic                 s1_valid;
  logic [1:0]           s1_op;
  logic signed [CB-1:0] s1_c1, s1_c2, s1_c3;
  logic signed [AW-1:0] s1_wa, s1_wt;
  logic signed [AW-1:0] s1_araw;

  // Quadrant fold and start of the first chain.
  csc_ctl_t             s2_ctl;
  logic signed [W-1:0]  s2_x, s2_y;
  logic signed [AW-1:0] s2_a;
  logic [SA_W-1:0]      s2_side;
  logic                 s2_an, s2_tn;
  logic signed [AW-1:0] s2_aq, s2_tq, s2_lat1;
  logic signed [W-1:0]  s2_vx, s2_vy;

  // First chain results.
  logic                 a_done;
  logic signed [W-1:0]  a_x, a_y;
  logic [SA_W-1:0]      a_side;
  logic [1:0]           a_op;
  logic signed [CB-1:0] a_c1, a_c2, a_c3;
  logic signed [AW-1:0] a_tq, a_lon1, a_lat1;
  logic                 a_tn;

  // Coordinates after the rotation.
  logic                 s3_valid;
  logic [1:0]           s3_op;
  logic signed [CB-1:0] s3_c1;
  logic signed [W-1:0]  s3_sx, s3_sy, s3_sz;
  logic signed [AW-1:0] s3_tq, s3_lon1, s3_lat1;
  logic                 s3_tn;
  logic signed [W-1:0]  s3_sx_next, s3_sy_next, s3_sz_next;

  // Start of the second chain.
  csc_ctl_t             s4_ctl;
  logic signed [W-1:0]  s4_x, s4_y;
  logic signed [AW-1:0] s4_a;
  logic [SB_W-1:0]      s4_side;
  logic                 s4_both0, s4_x0, s4_base;

  // Second chain results.
  logic                 b_done;
  logic signed [W-1:0]  b_x, b_y;
  logic signed [AW-1:0] b_a;
  logic [SB_W-1:0]      b_side;
  logic [1:0]           b_op;
  logic signed [CB-1:0] b_c1;
  logic                 b_both0, b_x0, b_base;
  logic signed [W-1:0]  b_sx, b_sy, b_sz;
  logic signed [AW-1:0] b_lon1, b_lat1;

  // Start of the third chain.
  csc_ctl_t             s5_ctl;
  logic signed [W-1:0]  s5_x, s5_y;
  logic [SC_W-1:0]      s5_side;
  logic signed [CB-1:0] s5_xo, s5_yo, s5_zo;
  logic signed [W-1:0]  s5_rho, s5_dlen;
  logic signed [AW-1:0] s5_theta, s5_dphi;
  logic                 s5_direct;

  // Third chain results.
  logic                 c_done;
  logic signed [W-1:0]  c_x;
  logic signed [AW-1:0] c_a;
  logic [SC_W-1:0]      c_side;
  logic signed [CB-1:0] c_xo, c_yo, c_zo;
  logic signed [AW-1:0] c_theta, c_dphi;
  logic                 c_direct;
  logic signed [W-1:0]  c_dlen;

  // Output stage.
  logic signed [W-1:0]  o_len;
  logic signed [AW-1:0] o_lon, o_lat;
  logic [CB-2:0]        o_radius;

  // The whole pipeline advances unless a finished result is being held.
  assign en         = !result_valid || result_ready;
  assign item_ready = en && !rst;

  // -------------------------------------------------------------------------
  // Input register
  // -------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_op  <= operation;
      s0_c1  <= first_coord;
      s0_c2  <= second_coord;
      s0_c3  <= third_coord;
      s0_ang <= rotation_angle;
    end
  end

  // -------------------------------------------------------------------------
  // Wrap both rotation angles into [0,360). The first chain turns by the
  // latitude for a spherical input, or by the negated rotation angle.
  // -------------------------------------------------------------------------
  assign s1_araw = (s0_op == OP_TO_RECT) ? ang_of(s0_c3) : -AW'(s0_ang);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_op <= s0_op;
      s1_c1 <= s0_c1;
      s1_c2 <= s0_c2;
      s1_c3 <= s0_c3;
      s1_wa <= wrap_full(s1_araw);
      s1_wt <= wrap_full(ang_of(s0_c2));
    end
  end

  // -------------------------------------------------------------------------
  // Fold each angle into [-90,90]; angles in the back half take a half turn
  // off and the start vector is negated instead.
  // -------------------------------------------------------------------------
  always_comb begin
    s2_an = 1'b0;
    s2_aq = s1_wa;
    if (s1_wa > D90 && s1_wa < D270) begin
      s2_an = 1'b1;
      s2_aq = s1_wa - D180;
    end else if (s1_wa >= D270) begin
      s2_aq = s1_wa - D360;
    end
    s2_tn = 1'b0;
    s2_tq = s1_wt;
    if (s1_wt > D90 && s1_wt < D270) begin
      s2_tn = 1'b1;
      s2_tq = s1_wt - D180;
    end else if (s1_wt >= D270) begin
      s2_tq = s1_wt - D360;
    end
    s2_lat1 = (s1_wa > D180) ? s1_wa - D360 : s1_wa;
    case (s1_op)
      OP_TO_RECT: begin
        s2_vx = W'(s1_c1);
        s2_vy = '0;
      end
      OP_ROT_X: begin
        s2_vx = W'(s1_c2);
        s2_vy = W'(s1_c3);
      end
      OP_ROT_Y: begin
        s2_vx = W'(s1_c1);
        s2_vy = W'(s1_c3);
      end
      default: begin
        s2_vx = W'(s1_c1);
        s2_vy = W'(s1_c2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_ctl <= '0;
    end else if (en) begin
      s2_ctl <= '{valid: s1_valid, vec: 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_x    <= s2_an ? -s2_vx : s2_vx;
      s2_y    <= s2_an ? -s2_vy : s2_vy;
      s2_a    <= s2_aq;
      s2_side <= {s1_op, s1_c1, s1_c2, s1_c3, s2_tq, s2_tn, s1_wt, s2_lat1};
    end
  end

  // First chain: the rotation, or the latitude turn of a spherical input.
  csc_chain #(
    .W(W), .AW(AW), .AF(ANGLE_FRAC), .STAGES(CORDIC_STAGES), .SIDE_W(SA_W)
  ) u_chain_a (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .start_ctl (s2_ctl),
    .start_x   (s2_x),
    .start_y   (s2_y),
    .start_a   (s2_a),
    .start_side(s2_side),
    .done      (a_done),
    .res_x     (a_x),
    .res_y     (a_y),
    .res_a     (),
    .res_side  (a_side)
  );

  assign {a_op, a_c1, a_c2, a_c3, a_tq, a_tn, a_lon1, a_lat1} = a_side;

  // -------------------------------------------------------------------------
  // Put the rotated pair back in place and saturate it. For a spherical
  // input the pair is the plane length and z, kept at full width.
  // -------------------------------------------------------------------------
  always_comb begin
    case (a_op)
      OP_TO_RECT: begin
        s3_sx_next = a_x;
        s3_sy_next = '0;
        s3_sz_next = a_y;
      end
      OP_ROT_X: begin
        s3_sx_next = W'(a_c1);
        s3_sy_next = W'(sat_coord(a_x));
        s3_sz_next = W'(sat_coord(a_y));
      end
      OP_ROT_Y: begin
        s3_sx_next = W'(sat_coord(a_x));
        s3_sy_next = W'(a_c2);
        s3_sz_next = W'(sat_coord(a_y));
      end
      default: begin
        s3_sx_next = W'(a_c1);
        s3_sy_next = W'(a_c2);
        s3_sz_next = W'(a_c3);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en) begin
      s3_valid <= a_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_op   <= a_op;
      s3_c1   <= a_c1;
      s3_sx   <= s3_sx_next;
      s3_sy   <= s3_sy_next;
      s3_sz   <= s3_sz_next;
      s3_tq   <= a_tq;
      s3_tn   <= a_tn;
      s3_lon1 <= a_lon1;
      s3_lat1 <= a_lat1;
    end
  end

  // -------------------------------------------------------------------------
  // Second chain setup. A spherical input turns its plane length by the
  // longitude. Otherwise the chain measures the xy plane: x is made
  // non-negative by a half turn, and a zero x is flagged so that the angle
  // comes out as exactly 0 or +-90 instead of the chain's estimate.
  // -------------------------------------------------------------------------
  assign s4_both0 = (s3_sx == 0) && (s3_sy == 0);
  assign s4_x0    = (s3_sx == 0) && (s3_sy != 0);
  assign s4_base  = s3_sx[W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl <= '0;
    end else if (en) begin
      s4_ctl <= '{valid: s3_valid, vec: (s3_op != OP_TO_RECT)};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (s3_op == OP_TO_RECT) begin
        s4_x <= s3_tn ? -s3_sx : s3_sx;
        s4_y <= '0;
        s4_a <= s3_tq;
      end else begin
        s4_x <= s4_base ? -s3_sx : s3_sx;
        s4_y <= s4_base ? -s3_sy : s3_sy;
        s4_a <= '0;
      end
      s4_side <= {s3_op, s3_c1, s4_both0, s4_x0, s4_base, s3_sx, s3_sy, s3_sz,
                  s3_lon1, s3_lat1};
    end
  end

  csc_chain #(
    .W(W), .AW(AW), .AF(ANGLE_FRAC), .STAGES(CORDIC_STAGES), .SIDE_W(SB_W)
  ) u_chain_b (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .start_ctl (s4_ctl),
    .start_x   (s4_x),
    .start_y   (s4_y),
    .start_a   (s4_a),
    .start_side(s4_side),
    .done      (b_done),
    .res_x     (b_x),
    .res_y     (b_y),
    .res_a     (b_a),
    .res_side  (b_side)
  );

  assign {b_op, b_c1, b_both0, b_x0, b_base, b_sx, b_sy, b_sz, b_lon1, b_lat1} = b_side;

  // -------------------------------------------------------------------------
  // Final rectangular coordinates and the xy-plane length and longitude. A
  // zero plane length skips the chain: the latitude is then fixed by the
  // sign of z and the radius is |z|. A spherical input takes its radius and
  // angles straight through the same path.
  // -------------------------------------------------------------------------
  always_comb begin
    if (b_op == OP_TO_RECT) begin
      s5_xo     = sat_coord(b_x);
      s5_yo     = sat_coord(b_y);
      s5_zo     = sat_coord(b_sz);
      s5_rho    = '0;
      s5_theta  = b_lon1;
      s5_direct = 1'b1;
      s5_dlen   = W'(b_c1);
      s5_dphi   = b_lat1;
    end else begin
      s5_xo = b_sx[CB-1:0];
      s5_yo = b_sy[CB-1:0];
      s5_zo = b_sz[CB-1:0];
      if (b_both0) begin
        s5_rho   = '0;
        s5_theta = '0;
      end else if (b_x0) begin
        s5_rho   = b_sy[W-1] ? -b_sy : b_sy;
        s5_theta = b_sy[W-1] ? -D90 : D90;
      end else begin
        s5_rho   = b_x;
        s5_theta = b_base ? b_a + D180 : b_a;
      end
      s5_direct = (s5_rho == 0);
      s5_dlen   = b_sz[W-1] ? -b_sz : b_sz;
      if (b_sz > 0) s5_dphi = D90;
      else if (b_sz < 0) s5_dphi = -D90;
      else s5_dphi = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_ctl <= '0;
    end else if (en) begin
      s5_ctl <= '{valid: b_done, vec: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_x    <= s5_rho;
      s5_y    <= W'(s5_zo);
      s5_side <= {s5_xo, s5_yo, s5_zo, s5_theta, s5_dphi, s5_direct, s5_dlen};
    end
  end

  // Third chain: measures (plane length, z) for the radius and latitude.
  csc_chain #(
    .W(W), .AW(AW), .AF(ANGLE_FRAC), .STAGES(CORDIC_STAGES), .SIDE_W(SC_W)
  ) u_chain_c (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .start_ctl (s5_ctl),
    .start_x   (s5_x),
    .start_y   (s5_y),
    .start_a   ('0),
    .start_side(s5_side),
    .done      (c_done),
    .res_x     (c_x),
    .res_y     (),
    .res_a     (c_a),
    .res_side  (c_side)
  );

  assign {c_xo, c_yo, c_zo, c_theta, c_dphi, c_direct, c_dlen} = c_side;

  // -------------------------------------------------------------------------
  // Output register: clamp the radius and wrap both angles.
  // -------------------------------------------------------------------------
  always_comb begin
    o_len = c_direct ? c_dlen : c_x;
    o_lon = wrap_full(c_theta);
    o_lat = wrap_half(c_direct ? c_dphi : c_a);
    if (o_len < 0) o_radius = '0;
    else if (o_len > CMAX) o_radius = CMAX[CB-2:0];
    else o_radius = o_len[CB-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= c_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_out         <= c_xo;
      y_out         <= c_yo;
      z_out         <= c_zo;
      radius_out    <= o_radius;
      longitude_out <= o_lon[AB-2:0];
      latitude_out  <= o_lat[AB-2:0];
    end
  end

  // -------------------------------------------------------------------------
  // Assertions
  // -------------------------------------------------------------------------
  `CSC_ASSERT_IMPLY(a_lon_range, clk, rst, result_valid, longitude_out < D360)
  `CSC_ASSERT_IMPLY(a_lat_range, clk, rst, result_valid,
                    (latitude_out <= D180) && (latitude_out > -D180))
  `CSC_ASSERT_IMPLY(a_fold_range, clk, rst, s2_ctl.valid, (s2_a <= D90) && (s2_a >= -D90))
  `CSC_ASSERT_NEXT(a_drain, clk, rst, en && c_done, result_valid)

endmodule

`default_nettype wire

// File: hdl/csc_cell.sv
// ---------------------------------------------------------------------------
// CORDIC cell
// One micro-rotation step, in vectoring or rotation mode, registered.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_cell
  import csc_pkg::*;
#(
  parameter int W      = 36,
  parameter int AW     = 33,
  parameter int AF     = 22,
  parameter int STAGE  = 0,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  csc_ctl_t                 prev_ctl,
  input  logic signed [W-1:0]      prev_x,
  input  logic signed [W-1:0]      prev_y,
  input  logic signed [AW-1:0]     prev_a,
  input  logic        [SIDE_W-1:0] prev_side,
  output csc_ctl_t                 ctl,
  output logic signed [W-1:0]      x,
  output logic signed [W-1:0]      y,
  output logic signed [AW-1:0]     a,
  output logic        [SIDE_W-1:0] side
);

  localparam logic signed [AW-1:0] STEP = AW'(atan_deg(STAGE, AF));

  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic                up;

  assign dx = prev_y >>> STAGE;
  assign dy = prev_x >>> STAGE;
  // Vectoring drives y toward zero; rotation drives the residual angle to zero.
  assign up = prev_ctl.vec ? !prev_y[W-1] : prev_a[AW-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= '0;
    end else if (en) begin
      ctl <= prev_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= up ? prev_x + dx : prev_x - dx;
      y    <= up ? prev_y - dy : prev_y + dy;
      a    <= up ? prev_a + STEP : prev_a - STEP;
      side <= prev_side;
    end
  end

endmodule

`default_nettype wire

// File: hdl/csc_gain.sv
// ---------------------------------------------------------------------------
// CORDIC gain removal
// Two-stage floor(v * GAIN_Q31 / 2^31) built from two partial products.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_gain
  import csc_pkg::*;
#(
  parameter int W = 36
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] value,
  output logic signed [W-1:0] scaled
);

  logic        [61:0] plo;
  logic signed [W:0]  phi;

  always_ff @(posedge clk) begin
    if (en) begin
      plo    <= {31'd0, value[30:0]} * {31'd0, GAIN_Q31};
      phi    <= (W+1)'($signed(value[W-1:31])) * (W+1)'($signed({1'b0, GAIN_Q31}));
      scaled <= W'((W+2)'(phi) + (W+2)'($signed({1'b0, plo[61:31]})));
    end
  end

endmodule

`default_nettype wire

// File: hdl/csc_chain.sv
// ---------------------------------------------------------------------------
// CORDIC chain
// A row of CORDIC cells followed by the two-stage gain removal.
// ---------------------------------------------------------------------------
`default_nettype none

module csc_chain
  import csc_pkg::*;
#(
  parameter int W      = 36,
  parameter int AW     = 33,
  parameter int AF     = 22,
  parameter int STAGES = 24,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  csc_ctl_t                 start_ctl,
  input  logic signed [W-1:0]      start_x,
  input  logic signed [W-1:0]      start_y,
  input  logic signed [AW-1:0]     start_a,
  input  logic        [SIDE_W-1:0] start_side,
  output logic                     done,
  output logic signed [W-1:0]      res_x,
  output logic signed [W-1:0]      res_y,
  output logic signed [AW-1:0]     res_a,
  output logic        [SIDE_W-1:0] res_side
);

  csc_ctl_t                 ctl_s  [STAGES+1];
  logic signed [W-1:0]      x_s    [STAGES+1];
  logic signed [W-1:0]      y_s    [STAGES+1];
  logic signed [AW-1:0]     a_s    [STAGES+1];
  logic        [SIDE_W-1:0] side_s [STAGES+1];

  logic                     g_valid [2];
  logic signed [AW-1:0]     g_a     [2];
  logic        [SIDE_W-1:0] g_side  [2];

  assign ctl_s[0]  = start_ctl;
  assign x_s[0]    = start_x;
  assign y_s[0]    = start_y;
  assign a_s[0]    = start_a;
  assign side_s[0] = start_side;

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    csc_cell #(
      .W(W), .AW(AW), .AF(AF), .STAGE(i), .SIDE_W(SIDE_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .prev_ctl (ctl_s[i]),
      .prev_x   (x_s[i]),
      .prev_y   (y_s[i]),
      .prev_a   (a_s[i]),
      .prev_side(side_s[i]),
      .ctl      (ctl_s[i+1]),
      .x        (x_s[i+1]),
      .y        (y_s[i+1]),
      .a        (a_s[i+1]),
      .side     (side_s[i+1])
    );
  end

  csc_gain #(.W(W)) u_gain_x (
    .clk(clk), .en(en), .value(x_s[STAGES]), .scaled(res_x)
  );

  csc_gain #(.W(W)) u_gain_y (
    .clk(clk), .en(en), .value(y_s[STAGES]), .scaled(res_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid[0] <= 1'b0;
      g_valid[1] <= 1'b0;
    end else if (en) begin
      g_valid[0] <= ctl_s[STAGES].valid;
      g_valid[1] <= g_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_a[0]    <= a_s[STAGES];
      g_a[1]    <= g_a[0];
      g_side[0] <= side_s[STAGES];
      g_side[1] <= g_side[0];
    end
  end

  assign done     = g_valid[1];
  assign res_a    = g_a[1];
  assign res_side = g_side[1];

endmodule

`default_nettype wire
